[rtl/euler_to_quaternion_macros.svh]
// ----------------------------------------------------------------------------
// euler_to_quaternion assertion macros
// Shared concurrent check forms; clocked on clk, disabled during rst.
// ----------------------------------------------------------------------------
`ifndef EULER_TO_QUATERNION_MACROS_SVH
`define EULER_TO_QUATERNION_MACROS_SVH

// antecedent implies consequent (the consequent may carry a fixed delay)
`define E2Q_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// signed value stays within plus or minus lim whenever cond holds
`define E2Q_ASSERT_RANGE(label, cond, sig, lim, msg) \
  `E2Q_ASSERT_IMP(label, cond, ($signed(sig) <= (lim)) && ($signed(sig) >= -(lim)), msg)

`endif

[rtl/e2q_pkg.sv]
// ----------------------------------------------------------------------------
// e2q_pkg
// Types, fixed-point formats and the CORDIC arctangent table shared by the
// Euler-to-quaternion pipeline.
// ----------------------------------------------------------------------------
package e2q_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int QUAT_FRAC_BITS = 14;
  localparam int OUT_W          = QUAT_FRAC_BITS + 2;

  // half-angle phase, 2^32 per turn
  localparam int PHASE_W    = 32;
  localparam int HALF_SHIFT = PHASE_W - 1 - ANGLE_BITS;

  localparam int CORDIC_STEPS = 30;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int LANES        = 3;
  localparam int LANE_W       = $clog2(LANES);
  localparam int FRAC_Q       = 30;
  localparam int XY_W         = 32;
  localparam int Z_W          = PHASE_W + 2;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 32'sd652032874;

  localparam int PROD_W    = 2 * XY_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int OUT_SHIFT = 2 * FRAC_Q - QUAT_FRAC_BITS;
  localparam int FIN_W     = SUM_W - OUT_SHIFT;

  localparam logic signed [PROD_W-1:0] PAIR_HALF = PROD_W'(1) << (FRAC_Q - 1);
  localparam logic signed [SUM_W-1:0]  OUT_HALF  = SUM_W'(1) << (OUT_SHIFT - 1);
  localparam logic signed [OUT_W-1:0]  QUAT_LIM  = OUT_W'(1) << QUAT_FRAC_BITS;

  // load, micro-rotations, four product stages, output round
  localparam int LATENCY = CORDIC_STEPS + 6;

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] roll_angle;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] yaw_angle;
  } angles_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] quat_scalar;
    logic signed [OUT_W-1:0] quat_i;
    logic signed [OUT_W-1:0] quat_j;
    logic signed [OUT_W-1:0] quat_k;
  } quat_t;

  typedef struct packed {
    logic signed [XY_W-1:0] cos_roll;
    logic signed [XY_W-1:0] sin_roll;
    logic signed [XY_W-1:0] cos_pitch;
    logic signed [XY_W-1:0] sin_pitch;
    logic signed [XY_W-1:0] cos_yaw;
    logic signed [XY_W-1:0] sin_yaw;
  } trig_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] scalar;
    logic signed [SUM_W-1:0] vec_i;
    logic signed [SUM_W-1:0] vec_j;
    logic signed [SUM_W-1:0] vec_k;
  } quat_sum_t;

  // atan(2^-idx) in phase units
  function automatic logic signed [Z_W-1:0] atan_phase(input logic [STEP_W-1:0] idx);
    logic signed [Z_W-1:0] r;
    case (idx)
      5'd0:    r = 34'sd536870912;
      5'd1:    r = 34'sd316933406;
      5'd2:    r = 34'sd167458907;
      5'd3:    r = 34'sd85004756;
      5'd4:    r = 34'sd42667331;
      5'd5:    r = 34'sd21354465;
      5'd6:    r = 34'sd10679838;
      5'd7:    r = 34'sd5340245;
      5'd8:    r = 34'sd2670163;
      5'd9:    r = 34'sd1335087;
      5'd10:   r = 34'sd667544;
      5'd11:   r = 34'sd333772;
      5'd12:   r = 34'sd166886;
      5'd13:   r = 34'sd83443;
      5'd14:   r = 34'sd41722;
      5'd15:   r = 34'sd20861;
      5'd16:   r = 34'sd10430;
      5'd17:   r = 34'sd5215;
      5'd18:   r = 34'sd2608;
      5'd19:   r = 34'sd1304;
      5'd20:   r = 34'sd652;
      5'd21:   r = 34'sd326;
      5'd22:   r = 34'sd163;
      5'd23:   r = 34'sd81;
      5'd24:   r = 34'sd41;
      5'd25:   r = 34'sd20;
      5'd26:   r = 34'sd10;
      5'd27:   r = 34'sd5;
      5'd28:   r = 34'sd3;
      5'd29:   r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/e2q_cordic.sv]
// ----------------------------------------------------------------------------
// e2q_cordic
// Three-lane pipelined CORDIC: half-angle sine and cosine of roll, pitch and
// yaw, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module e2q_cordic (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  e2q_pkg::angles_t  angles,
  output logic              out_valid,
  output e2q_pkg::trig_t    trig
);

  localparam int STEPS = e2q_pkg::CORDIC_STEPS;
  localparam int LANES = e2q_pkg::LANES;
  localparam int XY_W  = e2q_pkg::XY_W;
  localparam int Z_W   = e2q_pkg::Z_W;
  localparam int AB    = e2q_pkg::ANGLE_BITS;

  logic [AB-1:0] ang [LANES];

  logic signed [XY_W-1:0] x [LANES][STEPS+1];
  logic signed [XY_W-1:0] y [LANES][STEPS+1];
  logic signed [Z_W-1:0]  z [LANES][STEPS+1];
  logic [STEPS:0]         vld;

  always_comb begin
    ang[0] = angles.roll_angle;
    ang[1] = angles.pitch_angle;
    ang[2] = angles.yaw_angle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[STEPS-1:0], in_valid};
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic signed [e2q_pkg::PHASE_W-1:0] phase;

    // exact halving: the angle lands one bit lower in a 2^32-per-turn phase
    assign phase = {ang[l][AB-1], ang[l], {e2q_pkg::HALF_SHIFT{1'b0}}};

    always_ff @(posedge clk) begin
      x[l][0] <= e2q_pkg::CORDIC_GAIN;
      y[l][0] <= '0;
      z[l][0] <= Z_W'(phase);
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic signed [XY_W-1:0] dx;
      logic signed [XY_W-1:0] dy;
      logic signed [Z_W-1:0]  da;

      assign dx = x[l][i] >>> i;
      assign dy = y[l][i] >>> i;
      assign da = e2q_pkg::atan_phase(e2q_pkg::STEP_W'(i));

      always_ff @(posedge clk) begin
        if (!z[l][i][Z_W-1]) begin
          x[l][i+1] <= x[l][i] - dy;
          y[l][i+1] <= y[l][i] + dx;
          z[l][i+1] <= z[l][i] - da;
        end else begin
          x[l][i+1] <= x[l][i] + dy;
          y[l][i+1] <= y[l][i] - dx;
          z[l][i+1] <= z[l][i] + da;
        end
      end
    end
  end

  assign out_valid      = vld[STEPS];
  assign trig.cos_roll  = x[0][STEPS];
  assign trig.sin_roll  = y[0][STEPS];
  assign trig.cos_pitch = x[1][STEPS];
  assign trig.sin_pitch = y[1][STEPS];
  assign trig.cos_yaw   = x[2][STEPS];
  assign trig.sin_yaw   = y[2][STEPS];

endmodule

[rtl/e2q_combine.sv]
// ----------------------------------------------------------------------------
// e2q_combine
// Triple-product network: roll/pitch pair products, Q30 rounding, products
// with the yaw terms and the signed sums of the four components.
// ----------------------------------------------------------------------------
module e2q_combine (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  e2q_pkg::trig_t      trig,
  output logic                out_valid,
  output e2q_pkg::quat_sum_t  sums
);

  localparam int XY_W   = e2q_pkg::XY_W;
  localparam int PROD_W = e2q_pkg::PROD_W;
  localparam int SUM_W  = e2q_pkg::SUM_W;
  localparam int FRAC_Q = e2q_pkg::FRAC_Q;
  localparam int PAIRS  = 4;

  // pair order: cr*cp, sr*sp, sr*cp, cr*sp
  logic signed [PROD_W-1:0] pair [PAIRS];
  logic signed [PROD_W-1:0] rnd  [PAIRS];
  logic signed [XY_W-1:0]   ab   [PAIRS];
  logic signed [PROD_W-1:0] tc   [PAIRS];
  logic signed [PROD_W-1:0] ts   [PAIRS];
  logic signed [XY_W-1:0]   cy1, sy1, cy2, sy2;
  logic [3:0]               vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    pair[0] <= trig.cos_roll * trig.cos_pitch;
    pair[1] <= trig.sin_roll * trig.sin_pitch;
    pair[2] <= trig.sin_roll * trig.cos_pitch;
    pair[3] <= trig.cos_roll * trig.sin_pitch;
    cy1     <= trig.cos_yaw;
    sy1     <= trig.sin_yaw;
    cy2     <= cy1;
    sy2     <= sy1;
  end

  for (genvar n = 0; n < PAIRS; n++) begin : g_pair
    assign rnd[n] = pair[n] + e2q_pkg::PAIR_HALF;

    always_ff @(posedge clk) begin
      ab[n] <= rnd[n][FRAC_Q+XY_W-1:FRAC_Q];
      tc[n] <= ab[n] * cy2;
      ts[n] <= ab[n] * sy2;
    end
  end

  always_ff @(posedge clk) begin
    sums.scalar <= SUM_W'(tc[0]) + SUM_W'(ts[1]);
    sums.vec_i  <= SUM_W'(tc[2]) - SUM_W'(ts[3]);
    sums.vec_j  <= SUM_W'(tc[3]) + SUM_W'(ts[2]);
    sums.vec_k  <= SUM_W'(ts[0]) - SUM_W'(tc[1]);
  end

  assign out_valid = vld[3];

endmodule

[rtl/euler_to_quaternion.sv]
// done and the quat result leave the same output register stage, so the result
// beat is valid in the cycle in which done is high.
// Throughput: one item per cycle; the 36-stage pipeline (angle load, 30 CORDIC
// micro-rotations, four product stages, output rounding) has no feedback.
// busy is high only while rst is held; the result receiver cannot stall.
// Reset clears the valid chain and done; data registers are not reset.
// ----------------------------------------------------------------------------
// euler_to_quaternion
// ZYX Euler angles to unit quaternion, scalar first, signed Q1.14 output.
// ----------------------------------------------------------------------------
`include "euler_to_quaternion_macros.svh"

module euler_to_quaternion (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  e2q_pkg::angles_t  angles,
  output logic              done,
  output e2q_pkg::quat_t    quat
);

  localparam int SUM_W     = e2q_pkg::SUM_W;
  localparam int FIN_W     = e2q_pkg::FIN_W;
  localparam int OUT_W     = e2q_pkg::OUT_W;
  localparam int OUT_SHIFT = e2q_pkg::OUT_SHIFT;

  logic                accept;
  logic                trig_valid;
  e2q_pkg::trig_t      trig;
  logic                sum_valid;
  e2q_pkg::quat_sum_t  sums;

  // round half up to the output grid, then clamp to plus or minus one
  function automatic logic signed [OUT_W-1:0] round_clamp(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] r;
    logic signed [FIN_W-1:0] v;
    logic signed [OUT_W-1:0] res;
    r = s + e2q_pkg::OUT_HALF;
    v = r[SUM_W-1:OUT_SHIFT];
    if (v > FIN_W'(e2q_pkg::QUAT_LIM)) begin
      res = e2q_pkg::QUAT_LIM;
    end else if (v < -FIN_W'(e2q_pkg::QUAT_LIM)) begin
      res = -e2q_pkg::QUAT_LIM;
    end else begin
      res = v[OUT_W-1:0];
    end
    return res;
  endfunction

  assign busy   = rst;
  assign accept = start && !busy;

  e2q_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .angles    (angles),
    .out_valid (trig_valid),
    .trig      (trig)
  );

  e2q_combine u_combine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (trig_valid),
    .trig      (trig),
    .out_valid (sum_valid),
    .sums      (sums)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    quat.quat_scalar <= round_clamp(sums.scalar);
    quat.quat_i      <= round_clamp(sums.vec_i);
    quat.quat_j      <= round_clamp(sums.vec_j);
    quat.quat_k      <= round_clamp(sums.vec_k);
  end

  // every accepted beat comes out exactly one pipeline latency later
  `E2Q_ASSERT_IMP(a_latency, accept, ##(e2q_pkg::LATENCY) done, "result beat missing at pipeline latency")

  // zero rotation must give the identity quaternion
  `E2Q_ASSERT_IMP(a_identity, accept && (angles == '0), ##(e2q_pkg::LATENCY) (done && (quat.quat_scalar == e2q_pkg::QUAT_LIM) && (quat.quat_i == '0) && (quat.quat_j == '0) && (quat.quat_k == '0)), "zero angles did not give the identity")

  `E2Q_ASSERT_RANGE(a_scalar_range, done, quat.quat_scalar, e2q_pkg::QUAT_LIM, "scalar part out of range")
  `E2Q_ASSERT_RANGE(a_i_range, done, quat.quat_i, e2q_pkg::QUAT_LIM, "i component out of range")
  `E2Q_ASSERT_RANGE(a_k_range, done, quat.quat_k, e2q_pkg::QUAT_LIM, "k component out of range")

endmodule
